### design/msld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msld_pkg
// Shared types and constants for the slew-limited motor drive.
// ----------------------------------------------------------------------------
package msld_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_RAMP_RATE  = 2'd0;
    localparam logic [1:0] REG_RAMP_EN    = 2'd1;
    localparam logic [1:0] REG_DRIVE_MODE = 2'd2;
    localparam logic [1:0] REG_PWM_FS     = 2'd3;

    // drive modes; the unused code behaves as direction plus pwm
    localparam logic [1:0] MODE_EN_PWM    = 2'd0;
    localparam logic [1:0] MODE_DUAL_PWM  = 2'd1;
    localparam logic [1:0] MODE_DIR_PWM   = 2'd2;

    // power scale, Q2.14
    localparam logic signed [15:0] POWER_ONE     = 16'sd16384;
    localparam logic signed [15:0] POWER_NEG_ONE = -16'sd16384;

    // slowest allowed slew, 0.01 of full scale per second
    localparam logic [23:0] RATE_FLOOR = 24'd164;

    // floor(x / 1000) = (x * RECIP_1000) >> RECIP_SHIFT, exact for x < 2^25
    localparam int          RECIP_SHIFT = 35;
    localparam logic [25:0] RECIP_1000  = 26'd34359739;

    // pin values for one word
    typedef struct packed {
        logic [15:0] forward_out;
        logic [15:0] backward_out;
        logic [15:0] enable_out;
    } t_pins;

endpackage

### design/msld_pins.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msld_pins
// Maps an applied power to H-bridge pin values for the selected drive mode.
// ----------------------------------------------------------------------------
module msld_pins (
    input  logic signed [15:0] i_power,
    input  logic [1:0]         i_mode,
    input  logic [15:0]        i_full_scale,
    output msld_pkg::t_pins    o_pins
);
    import msld_pkg::*;

    logic [15:0] w_abs;
    logic [14:0] w_mag;
    logic [30:0] w_prod;
    logic [15:0] w_duty;
    logic        w_pos;
    logic        w_zero;

    // duty = floor(|power| * full_scale / 16384)
    assign w_abs  = i_power[15] ? (16'd0 - i_power) : i_power;
    assign w_mag  = w_abs[14:0];
    assign w_prod = {16'd0, w_mag} * {15'd0, i_full_scale};
    assign w_duty = w_prod[29:14];
    assign w_pos  = !i_power[15] && (i_power != 16'sd0);
    assign w_zero = (i_power == 16'sd0);

    // pin selection per mode
    always_comb begin
        o_pins = '0;
        if (!w_zero) begin
            case (i_mode)
                MODE_EN_PWM: begin
                    o_pins.forward_out  = {15'd0, w_pos};
                    o_pins.backward_out = {15'd0, !w_pos};
                    o_pins.enable_out   = w_duty;
                end
                MODE_DUAL_PWM: begin
                    o_pins.forward_out  = w_pos ? w_duty : 16'd0;
                    o_pins.backward_out = w_pos ? 16'd0 : w_duty;
                end
                default: begin
                    o_pins.forward_out  = {15'd0, w_pos};
                    o_pins.backward_out = w_duty;
                end
            endcase
        end
    end

endmodule

### design/motor_slew_limited_drive_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_slew_limited_drive_top
// Slew-limited power command to H-bridge pin values.
// ----------------------------------------------------------------------------
// Takes one word per clock and passes it through the five-stage pipeline
// (time delta, rate multiply, divide by 1000 through a reciprocal multiply,
// power update, pin mapping into the output register); throughput is one
// word per cycle. The whole pipeline holds only while a finished result
// waits at the output. The first word after reset, or after ramping is
// turned off, with ramping on records its time and gives no result. The user
// must write configuration between bursts; the block does not enforce it.
// ----------------------------------------------------------------------------
module motor_slew_limited_drive_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream: [15:0] target_power, [47:16] now_ms
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,
    // master stream: [15:0] forward_out, [31:16] backward_out,
    // [47:32] enable_out, [63:48] applied_power
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [23:0] i_cfg_wdata
);
    import msld_pkg::*;

    // configuration registers
    logic [23:0] r_ramp_rate;
    logic        r_ramp_en;
    logic [1:0]  r_drive_mode;
    logic [15:0] r_pwm_fs;

    // timing state
    logic [31:0] r_last_time;
    logic        r_time_valid;

    // pipeline registers
    logic               r_a_valid;
    logic signed [15:0] r_a_target;
    logic [17:0]        r_a_elapsed;
    logic               r_a_sat;
    logic               r_b_valid;
    logic signed [15:0] r_b_target;
    logic [24:0]        r_b_prod;
    logic               r_b_sat;
    logic               r_c_valid;
    logic signed [15:0] r_c_target;
    logic [15:0]        r_c_step;
    logic               r_c_sat;
    logic               r_d_valid;
    logic signed [15:0] r_cur_power;
    logic               r_o_valid;
    logic [63:0]        r_o_data;

    logic               w_adv;
    logic               w_accept;
    logic signed [15:0] w_in_target;
    logic [31:0]        w_in_now;
    logic signed [15:0] w_clamped;
    logic [31:0]        w_elapsed;
    logic [23:0]        w_rate_eff;
    logic [41:0]        w_rate_prod;
    logic [50:0]        w_recip_prod;
    logic signed [16:0] w_diff;
    logic [16:0]        w_dist;
    logic signed [16:0] w_moved;
    logic signed [15:0] n_cur_power;
    t_pins              w_pins;

    assign w_adv           = !r_o_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;
    assign w_accept        = i_s_axis_tvalid && w_adv;
    assign w_in_target     = i_s_axis_tdata[15:0];
    assign w_in_now        = i_s_axis_tdata[47:16];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_rate  <= 24'd16384;
            r_ramp_en    <= 1'b0;
            r_drive_mode <= MODE_EN_PWM;
            r_pwm_fs     <= 16'd1023;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_RAMP_RATE:  r_ramp_rate  <= i_cfg_wdata;
                REG_RAMP_EN:    r_ramp_en    <= i_cfg_wdata[0];
                REG_DRIVE_MODE: r_drive_mode <= i_cfg_wdata[1:0];
                REG_PWM_FS:     r_pwm_fs     <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // timestamp bookkeeping; turning ramping off forgets the last time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time  <= 32'd0;
            r_time_valid <= 1'b0;
        end else if (i_cfg_we && (i_cfg_addr == REG_RAMP_EN) && !i_cfg_wdata[0]) begin
            r_last_time  <= 32'd0;
            r_time_valid <= 1'b0;
        end else if (w_accept) begin
            r_last_time  <= w_in_now;
            r_time_valid <= 1'b1;
        end
    end

    // stage a: clamp target, elapsed time; long gaps saturate the step
    assign w_clamped = (w_in_target > POWER_ONE)     ? POWER_ONE :
                       (w_in_target < POWER_NEG_ONE) ? POWER_NEG_ONE : w_in_target;
    assign w_elapsed = w_in_now - r_last_time;

    // stage b: rate times elapsed ms
    assign w_rate_eff  = (r_ramp_rate < RATE_FLOOR) ? RATE_FLOOR : r_ramp_rate;
    assign w_rate_prod = {18'd0, w_rate_eff} * {24'd0, r_a_elapsed};

    // stage c: divide by 1000 through the reciprocal
    assign w_recip_prod = {26'd0, r_b_prod} * {25'd0, RECIP_1000};

    // stage d: move the applied power toward the target
    assign w_diff  = {r_c_target[15], r_c_target} - {r_cur_power[15], r_cur_power};
    assign w_dist  = w_diff[16] ? (17'd0 - w_diff) : w_diff;
    assign w_moved = w_diff[16] ? ({r_cur_power[15], r_cur_power} - {1'b0, r_c_step})
                                : ({r_cur_power[15], r_cur_power} + {1'b0, r_c_step});

    always_comb begin
        if (!r_ramp_en || r_c_sat || (w_dist <= {1'b0, r_c_step})) begin
            n_cur_power = r_c_target;
        end else begin
            n_cur_power = w_moved[15:0];
        end
    end

    // pipeline valid bits and power state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_o_valid   <= 1'b0;
            r_cur_power <= 16'sd0;
        end else if (w_adv) begin
            r_a_valid <= w_accept && (r_time_valid || !r_ramp_en);
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_o_valid <= r_d_valid;
            if (r_c_valid) begin
                r_cur_power <= n_cur_power;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_target  <= w_clamped;
            r_a_elapsed <= w_elapsed[17:0];
            r_a_sat     <= |w_elapsed[31:18];
            r_b_target  <= r_a_target;
            r_b_prod    <= w_rate_prod[24:0];
            r_b_sat     <= r_a_sat || (|w_rate_prod[41:25]);
            r_c_target  <= r_b_target;
            r_c_step    <= w_recip_prod[50:RECIP_SHIFT];
            r_c_sat     <= r_b_sat;
            r_o_data    <= {r_cur_power, w_pins.enable_out, w_pins.backward_out,
                            w_pins.forward_out};
        end
    end

    // stage e: pin mapping into the output register
    msld_pins u_pins (
        .i_power      (r_cur_power),
        .i_mode       (r_drive_mode),
        .i_full_scale (r_pwm_fs),
        .o_pins       (w_pins)
    );

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;

    // applied power never leaves plus or minus one
    a_power_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_power <= POWER_ONE) && (r_cur_power >= POWER_NEG_ONE))
        else $error("applied power out of range");

    // enable pin is only driven in enable-pin mode
    a_enable_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_drive_mode != MODE_EN_PWM)) |-> (r_o_data[47:32] == 16'd0))
        else $error("enable pin driven outside enable-pin mode");

    // the time flag only drops when ramping is switched off
    a_time_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_time_valid) |->
            (!$past(i_rst_n) || $past(i_cfg_we && (i_cfg_addr == REG_RAMP_EN))))
        else $error("time flag cleared without a ramp-enable write");

    // without ramping the power follows the target straight away
    a_no_ramp_jump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && w_adv && !r_ramp_en) |=> (r_cur_power == $past(r_c_target)))
        else $error("power did not jump with ramping off");

endmodule

### dv/tb_motor_slew_limited_drive_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motor_slew_limited_drive_top
// Self-checking bench for the slew-limited H-bridge drive.
// ----------------------------------------------------------------------------
// Power commands go in on the slave stream in random bursts. Each accepted
// word updates a local copy of the drive state: target clamp, slew step from
// the rate and the elapsed time, and the pin mapping of the current mode.
// This gives the expected pin word. Pin words on the master stream, which
// stalls on its own pattern, are compared field by field in order. Directed
// tests cover the power extremes, every drive mode, the ramp corner cases and
// register masking. Random phases then change the settings between bursts.
// ----------------------------------------------------------------------------
module tb_motor_slew_limited_drive_top;
    import msld_pkg::*;

    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         DRAIN_CYCLES = 12;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} t_stall_kind;

    typedef struct packed {
        t_pins              pins;
        logic signed [15:0] power;
    } t_drive_word;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // [15:0] target_power, [47:16] now_ms
    logic [47:0] i_s_axis_tdata  = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // [15:0] forward_out, [31:16] backward_out, [47:32] enable_out,
    // [63:48] applied_power
    logic [63:0] o_m_axis_tdata;
    logic        i_cfg_we        = 1'b0;
    logic [1:0]  i_cfg_addr      = '0;
    logic [23:0] i_cfg_wdata     = '0;

    // local copy of the drive registers and state, reset values
    logic [23:0] slew_rate   = 24'd16384;
    logic        ramp_on     = 1'b0;
    logic [1:0]  bridge_mode = MODE_EN_PWM;
    logic [15:0] duty_full   = 16'd1023;
    int          power_now   = 0;
    logic [31:0] stamp_prev  = '0;
    bit          stamp_seen  = 1'b0;

    t_drive_word pending_drive [$];
    int          mismatch_count = 0;
    int          cycle_count;

    // sender burst shaping and receiver stall pattern
    int          burst_left = 0;
    int          burst_max  = 1;
    int          gap_max    = 0;
    t_stall_kind stall_mode = STALL_NONE;
    logic [3:0]  stall_phase = '0;

    motor_slew_limited_drive_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // receiver ready pattern
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 4'd1;
        case (stall_mode)
            STALL_NONE:     i_m_axis_tready <= 1'b1;
            STALL_RANDOM:   i_m_axis_tready <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: i_m_axis_tready <= ((stall_phase % 7) < 3);
            default:        i_m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // slew step and pin mapping for one accepted command word
    task automatic predict_drive(input logic signed [15:0] target_in,
                                 input logic [31:0] now_ms);
        int                target;
        int                diff;
        logic [31:0]       elapsed;
        longint unsigned   rate;
        longint unsigned   step;
        longint unsigned   distance;
        longint unsigned   duty;
        bit                pos;
        t_drive_word       res;
        target = target_in;
        if (target > POWER_ONE) target = POWER_ONE;
        if (target < POWER_NEG_ONE) target = POWER_NEG_ONE;
        if (stamp_seen || !ramp_on) begin
            rate     = (slew_rate < RATE_FLOOR) ? RATE_FLOOR : slew_rate;
            elapsed  = now_ms - stamp_prev;
            step     = (rate * 64'(elapsed)) / 64'd1000;
            diff     = target - power_now;
            distance = (diff < 0) ? -diff : diff;
            if (!ramp_on || distance <= step)
                power_now = target;
            else if (diff < 0)
                power_now = power_now - int'(step);
            else
                power_now = power_now + int'(step);

            duty = (power_now < 0) ? -power_now : power_now;
            duty = ((duty * 64'(duty_full)) >> 14) & 64'hFFFF;
            pos  = (power_now > 0);
            res  = '0;
            if (power_now != 0) begin
                case (bridge_mode)
                    MODE_EN_PWM: begin
                        res.pins.forward_out  = pos ? 16'd1 : 16'd0;
                        res.pins.backward_out = pos ? 16'd0 : 16'd1;
                        res.pins.enable_out   = duty[15:0];
                    end
                    MODE_DUAL_PWM: begin
                        res.pins.forward_out  = pos ? duty[15:0] : 16'd0;
                        res.pins.backward_out = pos ? 16'd0 : duty[15:0];
                    end
                    default: begin
                        res.pins.forward_out  = pos ? 16'd1 : 16'd0;
                        res.pins.backward_out = duty[15:0];
                    end
                endcase
            end
            res.power = power_now[15:0];
            pending_drive.push_back(res);
        end
        stamp_prev = now_ms;
        stamp_seen = 1'b1;
    endtask

    // one command word, with a random gap at the start of each burst
    task automatic send_power(input logic signed [15:0] target, input logic [31:0] now_ms);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, burst_max);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {now_ms, target};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_drive(target, now_ms);
    endtask

    // register write; the closing wait on the clock keeps the enable low between writes
    task automatic write_reg(input logic [1:0] addr, input logic [23:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (addr)
            REG_RAMP_RATE: slew_rate = data;
            REG_RAMP_EN: begin
                ramp_on = data[0];
                if (!data[0]) begin
                    stamp_seen = 1'b0;
                    stamp_prev = '0;
                end
            end
            REG_DRIVE_MODE: bridge_mode = data[1:0];
            default:        duty_full = data[15:0];
        endcase
        @(posedge i_clk);
    endtask

    // stop sending and let the pipeline empty, including words with no result
    task automatic drain;
        i_s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_drive.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic void compare_field(input string field, input int want, input int got);
        if (got != want) begin
            $error("%s expected %0d actual %0d", field, want, got);
            mismatch_count++;
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_drive_word got;
        t_drive_word want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.pins.forward_out  = o_m_axis_tdata[15:0];
            got.pins.backward_out = o_m_axis_tdata[31:16];
            got.pins.enable_out   = o_m_axis_tdata[47:32];
            got.power             = o_m_axis_tdata[63:48];
            if (pending_drive.size() == 0) begin
                $error("pin word 0x%h with no pending command", o_m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_drive.pop_front();
                compare_field("forward_out", want.pins.forward_out, got.pins.forward_out);
                compare_field("backward_out", want.pins.backward_out, got.pins.backward_out);
                compare_field("enable_out", want.pins.enable_out, got.pins.enable_out);
                compare_field("applied_power", want.power, got.power);
            end
        end
    end

    // jumps with ramping off at reset settings, clamp limits both ways
    task automatic test_power_extremes;
        gap_max    = 3;
        burst_max  = 4;
        stall_mode = STALL_RANDOM;
        send_power(16'sd16384, 32'd0);
        send_power(-16'sd32768, 32'hFFFF_FFFF);
        send_power(16'sd32767, 32'd1);
        send_power(16'sd0, 32'd2);
        send_power(16'sd1, 32'd3);
        send_power(-16'sd16385, 32'd4);
        send_power(-16'sd1, 32'd5);
    endtask

    // pin mapping in dual pwm, direction pwm and the unused mode code
    task automatic test_drive_modes;
        logic [1:0] mode_list [3];
        int         m;
        mode_list  = '{MODE_DUAL_PWM, MODE_DIR_PWM, MODE_UNUSED};
        gap_max    = 0;
        stall_mode = STALL_PERIODIC;
        for (m = 0; m < 3; m++) begin
            drain();
            write_reg(REG_DRIVE_MODE, 24'(mode_list[m]));
            send_power(16'sd8192, 32'd10 + m);
            send_power(-16'sd12000, 32'd20 + m);
        end
        // zero power drives every pin low
        send_power(16'sd0, 32'd30);
    endtask

    // first ramped word, exact step, rounding, time wrap, rate floor and max
    task automatic test_ramp_limits;
        gap_max    = 2;
        burst_max  = 2;
        stall_mode = STALL_HEAVY;
        drain();
        write_reg(REG_DRIVE_MODE, 24'(MODE_EN_PWM));
        write_reg(REG_RAMP_RATE, 24'd1000);
        write_reg(REG_RAMP_EN, 24'd1);
        send_power(16'sd0, 32'd100);
        send_power(16'sd5, 32'd105);
        send_power(16'sd16384, 32'd106);
        send_power(-16'sd16384, 32'hFFFF_FFF0);
        // elapsed counts across the 32-bit wrap
        send_power(16'sd16384, 32'h0000_0010);
        send_power(16'sd16384, 32'h0000_0010);
        drain();
        write_reg(REG_RAMP_RATE, 24'd0);
        send_power(16'sd16384, 32'h0000_001A);
        send_power(16'sd16384, 32'h0000_0020);
        drain();
        write_reg(REG_RAMP_RATE, 24'hFF_FFFF);
        send_power(-16'sd16384, 32'h0000_0800);
        // turning ramping off and on again restarts the time capture
        drain();
        write_reg(REG_RAMP_EN, 24'd0);
        write_reg(REG_RAMP_EN, 24'd1);
        send_power(16'sd100, 32'd5);
        send_power(16'sd100, 32'd6);
    endtask

    // write data wider than the register is cut to the register width
    task automatic test_register_masking;
        gap_max    = 0;
        stall_mode = STALL_NONE;
        drain();
        write_reg(REG_RAMP_EN, 24'hFF_FFFE);
        write_reg(REG_DRIVE_MODE, 24'hFF_FFFF);
        write_reg(REG_PWM_FS, 24'hFF_FFFF);
        send_power(16'sd16384, 32'd7);
        send_power(-16'sd16384, 32'd8);
        drain();
        write_reg(REG_PWM_FS, 24'h01_0000);
        send_power(16'sd9000, 32'd9);
    endtask

    // random settings per phase, mostly steady time steps with random targets
    task automatic test_random_traffic;
        int                 phase;
        int                 k;
        logic [23:0]        rate;
        logic [15:0]        full;
        logic [31:0]        clock_ms;
        logic signed [15:0] target;
        target = '0;
        for (phase = 0; phase < 10; phase++) begin
            drain();
            if (phase == 0) begin
                gap_max    = 0;
                stall_mode = STALL_NONE;
            end else begin
                case ($urandom_range(0, 2))
                    0:       gap_max = 0;
                    1:       gap_max = 3;
                    default: gap_max = 12;
                endcase
                burst_max  = $urandom_range(1, 16);
                stall_mode = t_stall_kind'($urandom_range(0, 3));
            end
            case ($urandom_range(0, 6))
                0:       rate = 24'd0;
                1:       rate = 24'd163;
                2:       rate = RATE_FLOOR;
                3:       rate = 24'hFF_FFFF;
                4:       rate = 24'd16384;
                5:       rate = 24'($urandom_range(165, 100000));
                default: rate = 24'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       full = 16'd1;
                1:       full = 16'hFFFF;
                2:       full = 16'd1023;
                default: full = 16'($urandom);
            endcase
            write_reg(REG_RAMP_RATE, rate);
            write_reg(REG_PWM_FS, 24'(full));
            write_reg(REG_DRIVE_MODE, 24'($urandom_range(0, 3)));
            write_reg(REG_RAMP_EN, 24'($urandom_range(0, 3) != 0));
            clock_ms = $urandom;
            for (k = 0; k < 50; k++) begin
                if ($urandom_range(0, 9) < 8) begin
                    clock_ms = clock_ms + $urandom_range(0, 40);
                    case ($urandom_range(0, 2))
                        0:       target = 16'($urandom);
                        1:       target = 16'($urandom_range(0, 32768) - 16384);
                        default: ;
                    endcase
                end else begin
                    // time jump or wrap with any target
                    clock_ms = $urandom;
                    target   = 16'($urandom);
                end
                send_power(target, clock_ms);
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_power_extremes();
        test_drive_modes();
        test_ramp_limits();
        test_register_masking();
        test_random_traffic();
        drain();
        if (mismatch_count == 0)
            $display("motor_slew_limited_drive_top verification clean");
        else
            $display("motor_slew_limited_drive_top verification failed");
        $finish;
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("motor_slew_limited_drive_top verification failed");
        $finish;
    end

endmodule
